/* src/loonn_pkg.sv */
// ----------------------------------------------------------------------------
// loonn_pkg
// Shared constants and the controller-to-datapath command type for the
// leave-one-out nearest neighbour classifier.
// ----------------------------------------------------------------------------
package loonn_pkg;

    localparam int MAX_SAMPLES   = 32;
    localparam int FEATURE_COUNT = 4;
    localparam int N_FEAT_IN     = 4;
    localparam int FEAT_W        = 16;
    localparam int LABEL_W       = 4;
    localparam int CMD_W         = 2;
    localparam int SIDX_W        = 6;
    localparam int IDX_W         = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int MAG_W         = FEAT_W + 1;
    localparam int TERM_W        = 2 * MAG_W;
    localparam int DIST_W        = TERM_W + $clog2(FEATURE_COUNT + 1);
    localparam int ROW_W         = FEATURE_COUNT * FEAT_W + LABEL_W;
    localparam int S_DATA_W      = 72;
    localparam int M_DATA_W      = 24;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        logic             latch_i;
        logic             diff_en;
        logic             term_en;
        logic             cmp_en;
        logic             clear_best;
        logic             clear_correct;
        logic             emit;
        logic [CNT_W-1:0] sample_num;
        logic             last;
    } loonn_cmd_t;

endpackage

/* src/loonn_ram.sv */
// ----------------------------------------------------------------------------
// loonn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module loonn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/loonn_ctrl.sv */
// ----------------------------------------------------------------------------
// loonn_ctrl
// Sequencer: takes commands, tracks the sample count and walks all pairs.
// ----------------------------------------------------------------------------
module loonn_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [loonn_pkg::CMD_W-1:0]       s_cmd,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output loonn_pkg::loonn_cmd_t             cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_LATI = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_DIFF = 3'd4;
    localparam logic [2:0] S_TERM = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [loonn_pkg::CNT_W-1:0] count_reg, count_next;
    logic [loonn_pkg::CNT_W-1:0] i_reg, i_next;
    logic [loonn_pkg::CNT_W-1:0] j_reg, j_next;
    logic [loonn_pkg::CNT_W-1:0] i_plus;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign i_plus   = i_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.waddr  = count_reg[loonn_pkg::IDX_W-1:0];
        cmd.raddr  = j_reg[loonn_pkg::IDX_W-1:0];
        cmd.sample_num = i_plus;
        cmd.last   = (i_plus == count_reg);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_cmd)
                        loonn_pkg::CMD_CLEAR: count_next = '0;
                        loonn_pkg::CMD_LOAD: begin
                            if (count_reg < loonn_pkg::CNT_W'(loonn_pkg::MAX_SAMPLES)) begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        loonn_pkg::CMD_RUN: begin
                            if (count_reg != '0) begin
                                i_next            = '0;
                                cmd.clear_correct = 1'b1;
                                state_next        = S_RDI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDI: begin
                cmd.raddr  = i_reg[loonn_pkg::IDX_W-1:0];
                state_next = S_LATI;
            end
            S_LATI: begin
                cmd.latch_i    = 1'b1;
                cmd.clear_best = 1'b1;
                j_next         = '0;
                state_next     = S_NEXT;
            end
            S_NEXT: begin
                if (j_reg == count_reg) begin
                    cmd.emit   = 1'b1;
                    state_next = S_OUT;
                end else if (j_reg == i_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff_en = 1'b1;
                state_next  = S_TERM;
            end
            S_TERM: begin
                cmd.term_en = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP: begin
                cmd.cmp_en = 1'b1;
                j_next     = j_reg + 1'b1;
                state_next = S_NEXT;
            end
            S_OUT: begin
                if (m_tready) begin
                    if (i_plus == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_plus;
                        state_next = S_RDI;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

/* src/loonn_dp.sv */
// ----------------------------------------------------------------------------
// loonn_dp
// Datapath: sample store, distance pipeline, best tracking, result register.
// ----------------------------------------------------------------------------
module loonn_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  loonn_pkg::loonn_cmd_t              cmd,
    input  logic [loonn_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_data,
    output logic [loonn_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int F  = loonn_pkg::FEATURE_COUNT;
    localparam int FW = loonn_pkg::FEAT_W;
    localparam int LW = loonn_pkg::LABEL_W;

    logic [loonn_pkg::ROW_W-1:0]  wdata, rdata;
    logic [loonn_pkg::ROW_W-1:0]  row_i_reg;
    logic [loonn_pkg::MAG_W-1:0]  mag_reg  [F];
    logic [loonn_pkg::MAG_W-1:0]  mag_next [F];
    logic [loonn_pkg::TERM_W-1:0] term_reg [F];
    logic [LW-1:0]                lab_j_reg, lab_t_reg;
    logic [loonn_pkg::DIST_W-1:0] sum, best_reg;
    logic                         found_reg, metric_reg;
    logic [LW-1:0]                near_label_reg;
    logic [loonn_pkg::CNT_W-1:0]  correct_reg, correct_next;
    logic                         ok;
    logic [loonn_pkg::M_DATA_W-1:0] out_reg;
    logic                         last_reg;

    always_comb begin
        for (int f = 0; f < F; f++) begin
            if (f < loonn_pkg::N_FEAT_IN) begin
                wdata[f*FW +: FW] = s_tdata[f*FW +: FW];
            end else begin
                wdata[f*FW +: FW] = '0;
            end
        end
        wdata[F*FW +: LW] = s_tdata[loonn_pkg::N_FEAT_IN*FW +: LW];
    end

    loonn_ram #(
        .WIDTH (loonn_pkg::ROW_W),
        .DEPTH (loonn_pkg::MAX_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr),
        .rdata (rdata)
    );

    always_comb begin
        for (int f = 0; f < F; f++) begin
            logic signed [loonn_pkg::MAG_W-1:0] d;
            d = $signed({row_i_reg[f*FW+FW-1], row_i_reg[f*FW +: FW]})
              - $signed({rdata[f*FW+FW-1], rdata[f*FW +: FW]});
            mag_next[f] = d[loonn_pkg::MAG_W-1] ? loonn_pkg::MAG_W'(-d)
                                                 : loonn_pkg::MAG_W'(d);
        end
        sum = '0;
        for (int f = 0; f < F; f++) begin
            sum = sum + loonn_pkg::DIST_W'(term_reg[f]);
        end
        ok           = found_reg && (near_label_reg == row_i_reg[F*FW +: LW]);
        correct_next = correct_reg + loonn_pkg::CNT_W'(ok);
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_i) begin
            row_i_reg <= rdata;
        end
        if (cmd.diff_en) begin
            mag_reg   <= mag_next;
            lab_j_reg <= rdata[F*FW +: LW];
        end
        if (cmd.term_en) begin
            for (int f = 0; f < F; f++) begin
                term_reg[f] <= metric_reg ? loonn_pkg::TERM_W'(mag_reg[f])
                                          : mag_reg[f] * mag_reg[f];
            end
            lab_t_reg <= lab_j_reg;
        end
        if (cmd.cmp_en && (!found_reg || sum < best_reg)) begin
            best_reg       <= sum;
            near_label_reg <= lab_t_reg;
        end else if (cmd.clear_best) begin
            near_label_reg <= '0;
        end
        if (cmd.emit) begin
            out_reg  <= {6'd0, loonn_pkg::SIDX_W'(correct_next), ok, found_reg,
                         near_label_reg, loonn_pkg::SIDX_W'(cmd.sample_num)};
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            metric_reg  <= 1'b0;
            correct_reg <= '0;
        end else begin
            if (cfg_valid) begin
                metric_reg <= cfg_data;
            end
            if (cmd.clear_best) begin
                found_reg <= 1'b0;
            end else if (cmd.cmp_en) begin
                found_reg <= 1'b1;
            end
            if (cmd.clear_correct) begin
                correct_reg <= '0;
            end else if (cmd.emit) begin
                correct_reg <= correct_next;
            end
        end
    end

    assign m_tdata = out_reg;
    assign m_tlast = last_reg;

endmodule

/* src/leave_one_out_nearest_neighbour.sv */
// ----------------------------------------------------------------------------
// leave_one_out_nearest_neighbour
// Stores labelled samples and classifies each by its nearest other sample.
// ----------------------------------------------------------------------------
// Load and clear words are taken while idle. A run word emits one result word
// per stored sample; each sample fetches its own row, passes over itself,
// then takes a store read, difference, term, and sum and compare for each
// other sample, and then emits its result. The pair loop is unpipelined and
// the sample store has a single read port, so one pair is handled at a time.
// No input word is taken while a run is in progress.
module leave_one_out_nearest_neighbour (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] feature_a, [31:16] feature_b, [47:32] feature_c,
    // [63:48] feature_d, [67:64] class_label, [71:68] zero
    input  logic [71:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] sample_index, [9:6] predicted_label, [10] has_neighbour,
    // [11] is_correct, [17:12] correct_so_far, [23:18] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    loonn_pkg::loonn_cmd_t cmd;

    assign cfg_ready = 1'b1;

    loonn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    loonn_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* src/loonn_chk.sv */
// ----------------------------------------------------------------------------
// loonn_chk
// Port-level checks for the nearest neighbour classifier.
// ----------------------------------------------------------------------------
module loonn_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken during a run");

    a_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[10])
        else $error("correct without a neighbour");

    a_nonb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[9:6] == 4'd0)
        else $error("label set without a neighbour");

endmodule

bind leave_one_out_nearest_neighbour loonn_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
